### rtl/biq_pkg.sv
// Shared constants, payload structs and lane control type of the biquad IIR filter.
`default_nettype none

package biq_pkg;

   // Field and state widths.
   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEF_WIDTH      = 32;
   localparam int STATE_WIDTH     = 58;
   localparam int CSR_INDEX_WIDTH = 3;

   // The multipliers consume the sample or output operand one digit per cycle.
   localparam int DIGIT_WIDTH       = 8;
   localparam int NUM_DIGITS        = (SAMPLE_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int OPERAND_WIDTH     = NUM_DIGITS * DIGIT_WIDTH;
   localparam int DIGIT_COUNT_WIDTH = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   // A coefficient times a sample fits in this many bits.
   localparam int PRODUCT_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;

   // Working width of the state additions, with headroom above both operands.
   localparam int SUM_WIDTH =
      ((PRODUCT_WIDTH > STATE_WIDTH) ? PRODUCT_WIDTH : STATE_WIDTH) + 2;

   // Register indexes of the CSR port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B0 = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B1 = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B2 = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_A1 = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_A2 = CSR_INDEX_WIDTH'(4);

   // Request payload.
   typedef struct packed {
      logic                           action;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } biq_req_type;

   // Response payload.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic                           clipped;
   } biq_rsp_type;

   // Control of one digit-serial multiplier lane.
   typedef struct packed {
      logic step;
      logic first;
      logic last;
   } biq_lane_ctl_type;

endpackage

`default_nettype wire

### rtl/biq_mul_lane.sv
// Digit-serial multiplier lane: parallel coefficient times an operand fed one digit a cycle.
`default_nettype none

module biq_mul_lane (
   input  logic                                    clock,
   input  biq_pkg::biq_lane_ctl_type               ctl,
   input  logic signed [biq_pkg::COEF_WIDTH-1:0]   coef,
   input  logic [biq_pkg::DIGIT_WIDTH-1:0]         digit,
   output logic signed [biq_pkg::PRODUCT_WIDTH-1:0] product
);
   import biq_pkg::*;

   localparam int HI_WIDTH   = COEF_WIDTH + 2;
   localparam int TERM_WIDTH = COEF_WIDTH + DIGIT_WIDTH + 1;
   localparam int TOTAL_WIDTH = HI_WIDTH + DIGIT_WIDTH;

   logic signed [HI_WIDTH-1:0]    hi_ff, hi_in;
   logic [OPERAND_WIDTH-1:0]      lo_ff, lo_in;
   logic signed [DIGIT_WIDTH:0]   digit_ext;
   logic signed [TERM_WIDTH-1:0]  term;
   logic signed [HI_WIDTH-1:0]    hi_base;
   logic signed [TOTAL_WIDTH-1:0] total;
   logic [HI_WIDTH+OPERAND_WIDTH-1:0] full;

   // Low digits are unsigned, the top digit carries the operand's sign.
   // Each step adds coef*digit to the upper part and shifts one digit
   // of finished product into the lower shift register.
   always_comb begin
      digit_ext = ctl.last ? {digit[DIGIT_WIDTH-1], digit} : {1'b0, digit};
      term      = coef * digit_ext;
      hi_base   = ctl.first ? '0 : hi_ff;
      total     = {{(TOTAL_WIDTH-HI_WIDTH){hi_base[HI_WIDTH-1]}}, hi_base}
                + {{(TOTAL_WIDTH-TERM_WIDTH){term[TERM_WIDTH-1]}}, term};
      hi_in     = total[TOTAL_WIDTH-1:DIGIT_WIDTH];
      lo_in     = OPERAND_WIDTH'({total[DIGIT_WIDTH-1:0], lo_ff} >> DIGIT_WIDTH);
   end

   // The full product sits in the two registers once the last digit is in.
   assign full    = {hi_ff, lo_ff};
   assign product = full[PRODUCT_WIDTH-1:0];

   // Partial product registers.
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

endmodule

`default_nettype wire

### rtl/biquad_iir_filter.sv
// Top level of the biquad IIR filter: transposed direct form II with digit-serial multipliers.
//
// Usage:
//   Requests arrive on req_valid/req_ready with req_payload (action, sample).
//   Action zero filters the sample, action one clears both delay states and
//   answers a zero, unclipped result. Every request yields one response on
//   rsp_valid/rsp_ready with rsp_payload (filtered, clipped).
//   Coefficients b0, b1, b2, a1, a2 are written on csr_valid/csr_ready with
//   csr_index 0 to 4; other indexes are dropped. csr_ready is always high,
//   and writes belong between samples.
//   A filter request passes through ST_MUL_X, ST_SUM_Y, ST_MUL_Y and
//   ST_UPDATE, which registers the response unless the receiver stalls;
//   then ST_DELIVER holds the result until the register is free. The next
//   request is taken back in ST_IDLE. The 8-bit digit-serial multiplier lanes
//   run over the sample once for the feed-forward products and over the
//   output once for the feedback ones. A clear request goes to ST_DELIVER.
//   Reset restores b0 to unity, the other coefficients and both delay states
//   to zero, and empties the response register.
//   The response register holds a result while the receiver stalls, and a
//   new request is still accepted and computed; only its delivery waits.
`default_nettype none

module biquad_iir_filter #(
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  biq_pkg::biq_req_type                    req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output biq_pkg::biq_rsp_type                    rsp_payload,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [biq_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [biq_pkg::COEF_WIDTH-1:0]          csr_data
);
   import biq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_SUM_Y,
      ST_MUL_Y,
      ST_UPDATE,
      ST_DELIVER
   } state_type;

   localparam logic signed [SUM_WIDTH-1:0] STATE_MAX =
      {{(SUM_WIDTH-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] STATE_MIN = ~STATE_MAX;
   localparam logic signed [SUM_WIDTH-1:0] SAMPLE_MAX =
      {{(SUM_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SAMPLE_MIN = ~SAMPLE_MAX;
   localparam logic signed [SUM_WIDTH-1:0] ROUND_BIAS =
      {{(SUM_WIDTH-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

   // Reset value of b0 is unity gain at the configured fraction width.
   localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET =
      {{(COEF_WIDTH-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

   state_type                        state_ff, state_in;
   logic signed [COEF_WIDTH-1:0]     b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic signed [COEF_WIDTH-1:0]     a1_ff, a1_in, a2_ff, a2_in;
   logic signed [STATE_WIDTH-1:0]    delay_one_ff, delay_one_in;
   logic signed [STATE_WIDTH-1:0]    delay_two_ff, delay_two_in;
   logic signed [STATE_WIDTH-1:0]    part_one_ff, part_one_in;
   logic signed [STATE_WIDTH-1:0]    part_two_ff, part_two_in;
   logic [OPERAND_WIDTH-1:0]         op_ff, op_in;
   logic [DIGIT_COUNT_WIDTH-1:0]     digit_cnt_ff, digit_cnt_in;
   logic signed [SAMPLE_WIDTH-1:0]   y_ff, y_in;
   logic                             clip_ff, clip_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   biq_rsp_type                      rsp_ff, rsp_in;

   biq_lane_ctl_type                 ctl_shared, ctl_x_only;
   logic signed [COEF_WIDTH-1:0]     coef_lane0, coef_lane1;
   logic signed [PRODUCT_WIDTH-1:0]  product0, product1, product2;

   logic                             req_accept, rsp_free, last_digit;
   logic signed [SUM_WIDTH-1:0]      acc, y_full;
   logic signed [SAMPLE_WIDTH-1:0]   y_sat;
   logic                             y_clip;

   function automatic logic signed [SUM_WIDTH-1:0] ext_product(
      input logic signed [PRODUCT_WIDTH-1:0] p
   );
      return {{(SUM_WIDTH-PRODUCT_WIDTH){p[PRODUCT_WIDTH-1]}}, p};
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] ext_state(
      input logic signed [STATE_WIDTH-1:0] s
   );
      return {{(SUM_WIDTH-STATE_WIDTH){s[STATE_WIDTH-1]}}, s};
   endfunction

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] r;
      if (v > STATE_MAX) begin
         r = STATE_MAX;
      end else if (v < STATE_MIN) begin
         r = STATE_MIN;
      end else begin
         r = v;
      end
      return r[STATE_WIDTH-1:0];
   endfunction

   // Handshake terms.
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign last_digit = (digit_cnt_ff == DIGIT_COUNT_WIDTH'(NUM_DIGITS - 1));
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Lanes 0 and 1 serve b0/b1 on the sample and a1/a2 on the output.
   always_comb begin
      ctl_shared.step  = (state_ff == ST_MUL_X) || (state_ff == ST_MUL_Y);
      ctl_shared.first = (digit_cnt_ff == '0);
      ctl_shared.last  = last_digit;
      ctl_x_only       = ctl_shared;
      ctl_x_only.step  = (state_ff == ST_MUL_X);
      coef_lane0       = (state_ff == ST_MUL_Y) ? a1_ff : b0_ff;
      coef_lane1       = (state_ff == ST_MUL_Y) ? a2_ff : b1_ff;
   end

   biq_mul_lane u_lane0 (
      .clock   (clock),
      .ctl     (ctl_shared),
      .coef    (coef_lane0),
      .digit   (op_ff[DIGIT_WIDTH-1:0]),
      .product (product0)
   );

   biq_mul_lane u_lane1 (
      .clock   (clock),
      .ctl     (ctl_shared),
      .coef    (coef_lane1),
      .digit   (op_ff[DIGIT_WIDTH-1:0]),
      .product (product1)
   );

   biq_mul_lane u_lane2 (
      .clock   (clock),
      .ctl     (ctl_x_only),
      .coef    (b2_ff),
      .digit   (op_ff[DIGIT_WIDTH-1:0]),
      .product (product2)
   );

   // Output sample: round half up, shift down, saturate to the sample range.
   always_comb begin
      acc    = ext_product(product0) + ext_state(delay_one_ff) + ROUND_BIAS;
      y_full = acc >>> COEF_FRAC_BITS;
      y_clip = (y_full > SAMPLE_MAX) || (y_full < SAMPLE_MIN);
      if (y_full > SAMPLE_MAX) begin
         y_sat = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
      end else if (y_full < SAMPLE_MIN) begin
         y_sat = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat = y_full[SAMPLE_WIDTH-1:0];
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      delay_one_in = delay_one_ff;
      delay_two_in = delay_two_ff;
      part_one_in  = part_one_ff;
      part_two_in  = part_two_ff;
      op_in        = op_ff;
      digit_cnt_in = digit_cnt_ff;
      y_in         = y_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      // Coefficient writes; unknown indexes are dropped.
      if (csr_valid) begin
         case (csr_index)
            CSR_COEF_B0: b0_in = csr_data;
            CSR_COEF_B1: b1_in = csr_data;
            CSR_COEF_B2: b2_in = csr_data;
            CSR_COEF_A1: a1_in = csr_data;
            CSR_COEF_A2: a2_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_payload.action) begin
                  delay_one_in = '0;
                  delay_two_in = '0;
                  y_in         = '0;
                  clip_in      = 1'b0;
                  state_in     = ST_DELIVER;
               end else begin
                  op_in        = OPERAND_WIDTH'(req_payload.sample);
                  digit_cnt_in = '0;
                  state_in     = ST_MUL_X;
               end
            end
         end
         ST_MUL_X, ST_MUL_Y: begin
            op_in = op_ff >> DIGIT_WIDTH;
            if (last_digit) begin
               digit_cnt_in = '0;
               state_in     = (state_ff == ST_MUL_X) ? ST_SUM_Y : ST_UPDATE;
            end else begin
               digit_cnt_in = digit_cnt_ff + DIGIT_COUNT_WIDTH'(1);
            end
         end
         ST_SUM_Y: begin
            y_in        = y_sat;
            clip_in     = y_clip;
            part_one_in = sat_state(ext_state(delay_two_ff) + ext_product(product1));
            part_two_in = sat_state(ext_product(product2));
            op_in       = OPERAND_WIDTH'(y_sat);
            state_in    = ST_MUL_Y;
         end
         ST_UPDATE: begin
            delay_one_in = sat_state(ext_state(part_one_ff) - ext_product(product0));
            delay_two_in = sat_state(ext_state(part_two_ff) - ext_product(product1));
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.filtered = y_ff;
               rsp_in.clipped  = clip_ff;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.filtered = y_ff;
               rsp_in.clipped  = clip_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, coefficients, delays, datapath registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         b0_ff        <= COEF_B0_RESET;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         digit_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b0_ff        <= b0_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
         digit_cnt_ff <= digit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      part_one_ff <= part_one_in;
      part_two_ff <= part_two_in;
      op_ff       <= op_in;
      y_ff        <= y_in;
      clip_ff     <= clip_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire

### rtl/biq_checker.sv
// Port-level assertions of the biquad IIR filter and the bind that attaches them.
`default_nettype none

module biq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input biq_pkg::biq_rsp_type rsp_payload
);
   import biq_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // A clipped result sits at one end of the sample range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.clipped |->
         (rsp_payload.filtered == OUT_MAX) || (rsp_payload.filtered == OUT_MIN))
      else $error("clipped result is not a range limit");

   // One request at a time: ready drops right after an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is at work");

   // Reset empties the response register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### bench/biquad_iir_filter_tb.sv
// Self-checking testbench of the biquad IIR filter with a bit-exact predictor.
module biquad_iir_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import biq_pkg::*;

   localparam int FRAC_BITS       = 30;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int PHASE_ITEMS     = 250;
   localparam int MODE_BLOCK      = 50;
   localparam int PRESSURE_HOLD   = 400;
   localparam int PRESSURE_ITEMS  = 30;
   localparam int END_WAIT_CYCLES = 20;

   // Request actions.
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // Saturation bounds of the output sample and of the delay states.
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint STATE_MAX  = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;

   localparam logic [COEF_WIDTH-1:0] COEF_MAX = 32'h7fff_ffff;
   localparam logic [COEF_WIDTH-1:0] COEF_MIN = 32'h8000_0000;
   localparam logic [COEF_WIDTH-1:0] COEF_ONE = 32'h4000_0000;

   typedef enum int {
      COEF_FULL,
      COEF_MODERATE,
      COEF_ALL_MAX,
      COEF_ALL_MIN,
      COEF_MIXED_EXTREMES
   } coef_style_e;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   biq_req_type                req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   biq_rsp_type                rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0]      csr_data = '0;

   // Predictor state: coefficients and the two delay accumulators.
   longint      coef_q [5];
   longint      state_one;
   longint      state_two;
   biq_rsp_type pending_outputs [$];
   biq_rsp_type expected_rsp;
   int          error_count = 0;

   // Idling controls of the sender and the receiver.
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int hold_request = 0;

   biquad_iir_filter #(
      .COEF_FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint clamp_to(input longint value, input longint hi);
      if (value > hi) return hi;
      if (value < -hi - 1) return -hi - 1;
      return value;
   endfunction

   // One filter step: rounded, saturated output, then the delay update; a clear zeroes both delays.
   function automatic biq_rsp_type filter_step(input biq_req_type req);
      longint      x;
      longint      acc;
      longint      y;
      longint      sat;
      longint      d1;
      longint      d2;
      biq_rsp_type res;
      res = '0;
      if (req.action == ACT_CLEAR) begin
         state_one = 0;
         state_two = 0;
         return res;
      end
      x   = longint'($signed(req.sample));
      acc = coef_q[CSR_COEF_B0] * x + state_one + (longint'(1) <<< (FRAC_BITS - 1));
      y   = acc >>> FRAC_BITS;
      sat = clamp_to(y, SAMPLE_MAX);
      res.clipped  = (sat != y);
      res.filtered = sat[SAMPLE_WIDTH-1:0];
      // The feedback terms use the saturated output.
      d1 = clamp_to(state_two + coef_q[CSR_COEF_B1] * x, STATE_MAX);
      d1 = clamp_to(d1 - coef_q[CSR_COEF_A1] * sat, STATE_MAX);
      d2 = clamp_to(coef_q[CSR_COEF_B2] * x, STATE_MAX);
      d2 = clamp_to(d2 - coef_q[CSR_COEF_A2] * sat, STATE_MAX);
      state_one = d1;
      state_two = d2;
      return res;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 4))
            0: return SAMPLE_WIDTH'(SAMPLE_MAX);
            1: return SAMPLE_WIDTH'(-SAMPLE_MAX - 1);
            2: return '0;
            3: return '1;
            default: return SAMPLE_WIDTH'(1);
         endcase
      end
      if (r < 40) return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
      return SAMPLE_WIDTH'($urandom);
   endfunction

   function automatic logic [COEF_WIDTH-1:0] random_coef(input coef_style_e style);
      case (style)
         COEF_MODERATE: return COEF_WIDTH'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
         COEF_ALL_MAX:  return COEF_MAX;
         COEF_ALL_MIN:  return COEF_MIN;
         COEF_MIXED_EXTREMES: begin
            case ($urandom_range(0, 3))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return '0;
               default: return COEF_WIDTH'($urandom);
            endcase
         end
         default: return COEF_WIDTH'($urandom);
      endcase
   endfunction

   // Offers one request, waits for its acceptance, then maybe idles.
   task automatic send_request(input logic act, input logic signed [SAMPLE_WIDTH-1:0] smp);
      biq_req_type req;
      int          gap;
      req.action  = act;
      req.sample  = smp;
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (!req_ready);
      pending_outputs.push_back(filter_step(req));
      @(negedge clock);
      gap = req_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [COEF_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_COEF_A2) coef_q[idx] = longint'($signed(data));
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_coefs(input logic [COEF_WIDTH-1:0] b0, input logic [COEF_WIDTH-1:0] b1,
                              input logic [COEF_WIDTH-1:0] b2, input logic [COEF_WIDTH-1:0] a1,
                              input logic [COEF_WIDTH-1:0] a2);
      write_csr(CSR_COEF_B0, b0);
      write_csr(CSR_COEF_B1, b1);
      write_csr(CSR_COEF_B2, b2);
      write_csr(CSR_COEF_A1, a1);
      write_csr(CSR_COEF_A2, a2);
   endtask

   // Stops offering requests and waits until every response has arrived.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_outputs.size() != 0);
   endtask

   // Reset coefficients give unity gain, so extremes pass unchanged.
   task automatic test_unity_gain();
      send_request(ACT_FILTER, SAMPLE_WIDTH'(SAMPLE_MAX));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-SAMPLE_MAX - 1));
      send_request(ACT_FILTER, '0);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(1));
      send_request(ACT_FILTER, '1);
      wait_for_idle();
   endtask

   // Half gain puts odd samples exactly on a rounding tie.
   task automatic test_rounding();
      write_coefs(32'h2000_0000, '0, '0, '0, '0);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(1));
      send_request(ACT_FILTER, '1);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(3));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-3));
      wait_for_idle();
   endtask

   // Extreme coefficients drive the output into both saturation limits.
   task automatic test_saturation();
      write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(SAMPLE_MAX));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(SAMPLE_MAX));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-SAMPLE_MAX - 1));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-SAMPLE_MAX - 1));
      wait_for_idle();
      write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(SAMPLE_MAX));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-SAMPLE_MAX - 1));
      wait_for_idle();
   endtask

   // A clear in the middle of a stream zeroes the delays and ignores its sample.
   task automatic test_clear();
      write_coefs(32'h3000_0000, 32'h2000_0000, 32'hf000_0000, 32'he000_0000, 32'h1000_0000);
      send_request(ACT_FILTER, SAMPLE_WIDTH'(24'h40_0000));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(-24'sh30_0000));
      send_request(ACT_CLEAR, SAMPLE_WIDTH'(SAMPLE_MAX));
      send_request(ACT_FILTER, SAMPLE_WIDTH'(24'h10_0000));
      wait_for_idle();
   endtask

   // Writes to indexes above the last coefficient must leave the filter alone.
   task automatic test_ignored_index();
      for (int i = 1; i <= 3; i++) begin
         write_csr(CSR_INDEX_WIDTH'(CSR_COEF_A2 + i), COEF_WIDTH'($urandom));
      end
      send_request(ACT_FILTER, random_sample());
      send_request(ACT_FILTER, random_sample());
      wait_for_idle();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      write_coefs(random_coef(COEF_MODERATE), random_coef(COEF_MODERATE),
                  random_coef(COEF_MODERATE), random_coef(COEF_MODERATE),
                  random_coef(COEF_MODERATE));
      req_idle     = 1'b0;
      hold_request = PRESSURE_HOLD;
      repeat (PRESSURE_ITEMS) send_request(ACT_FILTER, random_sample());
      req_idle = 1'b1;
      wait_for_idle();
   endtask

   // Random streams over several coefficient settings, with occasional clears.
   task automatic test_random_phases();
      coef_style_e styles [7];
      coef_style_e style;
      logic        act;
      styles = '{COEF_FULL, COEF_MODERATE, COEF_ALL_MAX, COEF_ALL_MIN,
                 COEF_MIXED_EXTREMES, COEF_MODERATE, COEF_FULL};
      foreach (styles[p]) begin
         style = styles[p];
         write_coefs(random_coef(style), random_coef(style), random_coef(style),
                     random_coef(style), random_coef(style));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % MODE_BLOCK == 0) begin
               req_idle = ($urandom_range(0, 3) != 0);
               rsp_idle = ($urandom_range(0, 3) != 0);
            end
            act = ($urandom_range(0, 19) == 0) ? ACT_CLEAR : ACT_FILTER;
            send_request(act, random_sample());
         end
         wait_for_idle();
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // Response receiver with random stalls and the long hold-off on request.
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected response filtered %0d clipped %0b", $time,
                     rsp_payload.filtered, rsp_payload.clipped);
            error_count++;
         end else begin
            expected_rsp = pending_outputs.pop_front();
            if (rsp_payload.filtered !== expected_rsp.filtered) begin
               $display("%0t: filtered expected %0d actual %0d", $time,
                        expected_rsp.filtered, rsp_payload.filtered);
               error_count++;
            end
            if (rsp_payload.clipped !== expected_rsp.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $time,
                        expected_rsp.clipped, rsp_payload.clipped);
               error_count++;
            end
         end
      end
   end

   // End the run when no handshake happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("biquad_iir_filter regression: fail");
      $finish;
   end

   initial begin
      coef_q    = '{longint'($signed(COEF_ONE)), 0, 0, 0, 0};
      state_one = 0;
      state_two = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_unity_gain();
      test_rounding();
      test_saturation();
      test_clear();
      test_ignored_index();
      test_backpressure();
      test_random_phases();

      repeat (END_WAIT_CYCLES) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_outputs.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("biquad_iir_filter regression: pass");
      end else begin
         $display("biquad_iir_filter regression: fail");
      end
      $finish;
   end

endmodule
